// ===== sv/wgm_pkg.sv =====
package wgm_pkg;

  localparam int unsigned CHAR_W = 16;

  localparam logic [CHAR_W-1:0] CH_STAR     = 16'h002A;
  localparam logic [CHAR_W-1:0] CH_QUESTION = 16'h003F;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 16'h005A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } wgm_op_e;

  // broadcast to every cell
  typedef struct packed {
    logic              rearm;
    logic              step;
    logic              append;
    logic              fold;
    logic [CHAR_W-1:0] ch;    // raw character, written on append
    logic [CHAR_W-1:0] text;  // folded text character, compared on step
  } wgm_ctl_t;

  // handed from cell p to cell p+1
  typedef struct packed {
    logic skip;   // star closure: position p+1 reachable without consuming
    logic shift;  // position p+1 reached by consuming the current character
  } wgm_link_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic             en);
    logic [CHAR_W-1:0] r;
    r = c;
    if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== sv/wgm_cell.sv =====
module wgm_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wgm_pkg::wgm_ctl_t   ctl_i,
  input  logic [LEN_W-1:0]    len_i,
  input  wgm_pkg::wgm_link_t  link_i,
  output wgm_pkg::wgm_link_t  link_o,
  output logic                clo_o
);
  import wgm_pkg::*;

  logic [CHAR_W-1:0] char_q;
  logic              raw_q, raw_d;
  logic              in_pat;
  logic              is_star;
  logic              hit;
  logic              clo;

  assign in_pat  = len_i > LEN_W'(IDX);
  assign is_star = char_q == CH_STAR;
  assign hit     = (char_q == CH_QUESTION) || (fold_char(char_q, ctl_i.fold) == ctl_i.text);

  // raw_q holds the set before star closure; closure ripples in from the left
  assign clo          = raw_q | link_i.skip;
  assign clo_o        = clo;
  assign link_o.skip  = clo & in_pat & is_star;
  assign link_o.shift = clo & in_pat & ~is_star & hit;

  always_comb begin
    raw_d = raw_q;
    if (ctl_i.rearm) begin
      raw_d = (IDX == 0);
    end else if (ctl_i.step) begin
      raw_d = link_o.skip | link_i.shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= (IDX == 0);
    end else begin
      raw_q <= raw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.append && len_i == LEN_W'(IDX)) begin
      char_q <= ctl_i.ch;
    end
  end

endmodule

// ===== sv/wildcard_glob_matcher_core.sv =====
// Whole-string glob matcher ('*' any run, '?' one character).
// Input stream s_axis: tdata[1:0] opcode (clear, append pattern char, text
// char, end of text), tdata[17:2] character. Output stream m_axis carries one
// word per end-of-text: tdata[0] matched, tdata[1] pattern overflow.
// The pattern sits in a row of MAX_PATTERN cells, one character each; every
// cell holds one bit of the active position set and passes star closure and
// advance bits to its right neighbor, so all positions take a text character
// together. One word is accepted per cycle whatever its opcode, while s_axis_tready_o is high.
// The result of an end-of-text word is registered and is valid on m_axis in
// the cycle after it is accepted. The output register frees up in the same
// cycle it is read, so s_axis_tready_o stays high unless a result is held by
// a stalled receiver; then input waits until m_axis_tready_i rises.
// Reset empties the pattern, clears the overflow flag and case folding, and
// arms the matcher at the start position. No clearing pass is needed.
// cfg_wdata_i = 1 folds ASCII letters; write only while idle.
module wildcard_glob_matcher_core #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // case_fold
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // opcode[1:0], character[17:2], zero fill
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // matched[0], pattern_overflow[1], zero fill
);
  import wgm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  logic              in_acc;
  wgm_op_e           op;
  logic [CHAR_W-1:0] ch;
  wgm_ctl_t          ctl;

  logic              fold_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic              raw_end_q, raw_end_d;
  logic              out_valid_q, out_valid_d;
  logic              matched_q, matched_d;
  logic              out_ovf_q, out_ovf_d;

  wgm_link_t         link [MAX_PATTERN];
  logic [MAX_PATTERN:0] clo;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign op              = wgm_op_e'(s_axis_tdata_i[1:0]);
  assign ch              = s_axis_tdata_i[CHAR_W+1:2];

  assign ctl.rearm  = in_acc && op != OP_TEXT;
  assign ctl.step   = in_acc && op == OP_TEXT;
  assign ctl.append = in_acc && op == OP_APPEND && len_q != LEN_MAX;
  assign ctl.fold   = fold_q;
  assign ctl.ch     = ch;
  assign ctl.text   = fold_char(ch, fold_q);

  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
    wgm_link_t link_in;
    if (p == 0) begin : g_first
      assign link_in = '0;
    end else begin : g_rest
      assign link_in = link[p-1];
    end
    wgm_cell #(
      .IDX   (p),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .len_i  (len_q),
      .link_i (link_in),
      .link_o (link[p]),
      .clo_o  (clo[p])
    );
  end

  // past the last cell: reached by consuming or through a star in the last cell, never itself a star
  assign clo[MAX_PATTERN] = raw_end_q | link[MAX_PATTERN-1].skip;

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    raw_end_d   = raw_end_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    matched_d   = matched_q;
    out_ovf_d   = out_ovf_q;
    if (in_acc) begin
      case (op)
        OP_CLEAR: begin
          len_d     = '0;
          ovf_d     = 1'b0;
          raw_end_d = 1'b0;
        end
        OP_APPEND: begin
          if (len_q != LEN_MAX) begin
            len_d = len_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          raw_end_d = 1'b0;
        end
        OP_TEXT: begin
          raw_end_d = link[MAX_PATTERN-1].shift;
        end
        OP_END: begin
          raw_end_d   = 1'b0;
          out_valid_d = 1'b1;
          matched_d   = clo[len_q];
          out_ovf_d   = ovf_q;
        end
        default: begin
          raw_end_d = raw_end_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q      <= 1'b0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      raw_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fold_q <= cfg_wdata_i;
      end
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      raw_end_q   <= raw_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    out_ovf_q <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_ovf_q, matched_q};

  // rearm leaves the start position active
  a_rearm_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op != OP_TEXT) |=> clo[0])
    else $error("start position not active after rearm");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LEN_MAX))
    else $error("overflow flag set with room left in the pattern");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_MAX)
    else $error("pattern length beyond capacity");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && op == OP_END))
    else $error("result word without an accepted end of text");

endmodule

// ===== dv/tb_wildcard_glob_matcher_core.sv =====
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_core;
  import wgm_pkg::*;

  localparam int PAT_MAX     = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_WORDS  = 1250;

  localparam logic [CHAR_W-1:0] LC_A = 16'h0061;
  localparam logic [CHAR_W-1:0] LC_B = 16'h0062;
  localparam logic [CHAR_W-1:0] LC_C = 16'h0063;
  localparam logic [CHAR_W-1:0] LC_Q = 16'h0071;
  localparam logic [CHAR_W-1:0] LC_X = 16'h0078;
  localparam logic [CHAR_W-1:0] UC_B = 16'h0042;

  localparam logic [PAT_MAX:0] START_POS = {{PAT_MAX{1'b0}}, 1'b1};

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  typedef struct {
    wgm_op_e           op;
    logic [CHAR_W-1:0] ch;
    int                reps;
    bit                typed;
    bit                m;
    bit                o;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_wdata   = 1'b0;
  logic        s_valid     = 1'b0;
  logic        s_ready;
  logic [23:0] s_data      = '0;
  logic        m_valid;
  logic        m_ready     = 1'b0;
  logic [7:0]  m_data;

  // matcher state as predicted
  logic [CHAR_W-1:0] pat_q [PAT_MAX];
  int                pat_len  = 0;
  logic [PAT_MAX:0]  live_pos = START_POS;
  bit                ovf_seen = 1'b0;
  bit                fold_on  = 1'b0;

  verdict_t verdicts [$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int n_words        = 0;
  int n_checked      = 0;
  int n_hits         = 0;
  int n_ovf          = 0;
  int n_errors       = 0;

  script_row_t script [29] = '{
    '{OP_END,    16'h0000,    1, 1, 1, 0},  // empty pattern, empty text
    '{OP_TEXT,   16'h0000,    1, 0, 0, 0},  // code zero is a plain character
    '{OP_END,    16'h0000,    1, 1, 0, 0},
    '{OP_APPEND, CH_STAR,     1, 0, 0, 0},
    '{OP_APPEND, CH_STAR,     1, 0, 0, 0},
    '{OP_END,    16'h0000,    1, 1, 1, 0},  // stars only, empty text
    '{OP_APPEND, LC_A,        1, 0, 0, 0},
    '{OP_TEXT,   LC_X,        1, 0, 0, 0},
    '{OP_TEXT,   LC_A,        1, 0, 0, 0},
    '{OP_END,    16'h0000,    1, 0, 0, 0},
    '{OP_TEXT,   CH_UPPER_A,  1, 0, 0, 0},  // exact compare, case differs
    '{OP_END,    16'h0000,    1, 0, 0, 0},
    '{OP_CLEAR,  16'hFFFF,    1, 0, 0, 0},
    '{OP_APPEND, CH_QUESTION, 1, 0, 0, 0},
    '{OP_TEXT,   16'hFFFF,    1, 0, 0, 0},
    '{OP_END,    16'h0000,    1, 0, 0, 0},
    '{OP_END,    16'h0000,    1, 1, 0, 0},  // '?' needs a character
    '{OP_TEXT,   LC_Q,        1, 0, 0, 0},
    '{OP_APPEND, LC_B,        1, 0, 0, 0},  // rearms, 'q' forgotten
    '{OP_TEXT,   LC_B,        1, 0, 0, 0},
    '{OP_END,    16'h0000,    1, 0, 0, 0},
    '{OP_APPEND, CH_STAR,    31, 0, 0, 0},  // one past full
    '{OP_END,    16'h0000,    1, 1, 0, 1},  // leading '?' fails on empty text
    '{OP_APPEND, CH_STAR,     1, 0, 0, 0},  // still full
    '{OP_CLEAR,  16'h0000,    1, 0, 0, 0},
    '{OP_END,    16'h0000,    1, 1, 1, 0},  // clear drops overflow
    '{OP_APPEND, CH_STAR,     1, 0, 0, 0},
    '{OP_APPEND, LC_A,        1, 0, 0, 0},
    '{OP_TEXT,   LC_X,        1, 0, 0, 0}   // fold switched on after this
  };

  wildcard_glob_matcher_core #(
    .MAX_PATTERN(PAT_MAX)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CHAR_W-1:0] lower_letter(input logic [CHAR_W-1:0] c);
    if (fold_on && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // a star at a live position makes the next position live too
  function automatic logic [PAT_MAX:0] star_spread(input logic [PAT_MAX:0] s);
    logic [PAT_MAX:0] r;
    r = s;
    for (int p = 0; p < pat_len; p++) begin
      if (r[p] && pat_q[p] == CH_STAR) begin
        r[p+1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void glob_step(input wgm_op_e op, input logic [CHAR_W-1:0] ch,
                                    output bit has, output verdict_t v);
    logic [PAT_MAX:0] nxt;
    has = 1'b0;
    v   = '0;
    case (op)
      OP_CLEAR: begin
        pat_len  = 0;
        ovf_seen = 1'b0;
      end
      OP_APPEND: begin
        if (pat_len < PAT_MAX) begin
          pat_q[pat_len] = ch;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      OP_TEXT: begin
        nxt = '0;
        for (int p = 0; p < pat_len; p++) begin
          if (live_pos[p]) begin
            if (pat_q[p] == CH_STAR) begin
              nxt[p] = 1'b1;
            end else if (pat_q[p] == CH_QUESTION || lower_letter(pat_q[p]) == lower_letter(ch)) begin
              nxt[p+1] = 1'b1;
            end
          end
        end
        live_pos = star_spread(nxt);
        return;
      end
      default: begin
        has        = 1'b1;
        v.matched  = live_pos[pat_len];
        v.overflow = ovf_seen;
      end
    endcase
    live_pos = star_spread(START_POS);
  endfunction

  // one word on s_axis; typed rows carry their own expected verdict
  task automatic send_word(input wgm_op_e op, input logic [CHAR_W-1:0] ch,
                           input bit typed = 1'b0, input verdict_t tv = '0);
    bit       has;
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, ch, op};
    do @(posedge clk_i); while (!s_ready);
    glob_step(op, ch, has, v);
    if (has) begin
      verdicts.push_back(typed ? tv : v);
    end
    n_words++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_fold(input bit val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    fold_on    = val;
  endtask

  function automatic logic [CHAR_W-1:0] pick_letter();
    case ($urandom_range(4))
      0: return LC_A;
      1: return LC_B;
      2: return CH_UPPER_A;
      3: return UC_B;
      default: return LC_C;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_pat_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return CH_STAR;
    if (r < 40) return CH_QUESTION;
    if (r < 88) return pick_letter();
    return CHAR_W'($urandom);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_text_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return pick_letter();
    if (r < 88) return ($urandom_range(1) != 0) ? CH_STAR : CH_QUESTION;
    return CHAR_W'($urandom);
  endfunction

  // new pattern now and then, then a text that mostly fits it
  task automatic run_sequence();
    int unsigned       r;
    int                len;
    int                plen;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] snap [PAT_MAX];
    r = $urandom_range(99);
    if (r < 10) begin
      send_word(wgm_op_e'($urandom_range(3)), CHAR_W'($urandom));
      return;
    end
    if (r < 32) begin
      if ($urandom_range(4) != 0) send_word(OP_CLEAR, CHAR_W'($urandom));
      len = ($urandom_range(19) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
      for (int i = 0; i < len; i++) send_word(OP_APPEND, pick_pat_char());
    end
    if ($urandom_range(2) != 0) begin
      plen = pat_len;
      for (int i = 0; i < plen; i++) snap[i] = pat_q[i];
      for (int i = 0; i < plen; i++) begin
        c = snap[i];
        if (c == CH_STAR) begin
          len = $urandom_range(0, 2);
          for (int k = 0; k < len; k++) send_word(OP_TEXT, pick_text_char());
        end else begin
          if (c == CH_QUESTION) c = pick_text_char();
          else if ($urandom_range(3) == 0 && (c | CASE_OFFSET) >= LC_A &&
                   (c | CASE_OFFSET) <= LC_A + 25) c = c ^ CASE_OFFSET;
          if ($urandom_range(14) == 0) c = pick_text_char();
          send_word(OP_TEXT, c);
        end
      end
    end else begin
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) send_word(OP_TEXT, pick_text_char());
    end
    if ($urandom_range(11) == 0) begin
      // broken text: pattern touched before the end
      send_word(OP_APPEND, pick_pat_char());
    end
    send_word(OP_END, CHAR_W'($urandom));
  endtask

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (verdicts.size() == 0) begin
        $error("unexpected result word tdata=%h", m_data);
        n_errors++;
      end else begin
        want = verdicts.pop_front();
        n_checked++;
        if (m_data[0]) n_hits++;
        if (m_data[1]) n_ovf++;
        if (m_data[0] !== want.matched) begin
          $error("matched: expected %0b actual %0b", want.matched, m_data[0]);
          n_errors++;
        end
        if (m_data[1] !== want.overflow) begin
          $error("pattern_overflow: expected %0b actual %0b", want.overflow, m_data[1]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_wildcard_glob_matcher_core: errors");
    $finish;
  end

  initial begin
    int       target;
    bit       paused;
    verdict_t tv;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      tv.matched  = script[i].m;
      tv.overflow = script[i].o;
      for (int k = 0; k < script[i].reps; k++) begin
        send_word(script[i].op, script[i].ch, script[i].typed, tv);
      end
    end
    // fold turned on in the middle of a text
    drain_results();
    write_fold(1'b1);
    send_word(OP_TEXT, CH_UPPER_A);
    send_word(OP_END, 16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_fold(ph % 2 == 0);
      case (ph)
        0: begin send_idle_pct = 8;  stall_pct = 64; end
        1: begin send_idle_pct = 64; stall_pct = 8;  end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      target = n_words + RAND_WORDS / 4;
      paused = 1'b0;
      while (n_words < target) begin
        run_sequence();
        if (!paused && n_words > target - RAND_WORDS / 8) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    s_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d words, %0d end-of-text results checked", n_words, n_checked);
    $display("  %0d matches, %0d with overflow, fold off and on", n_hits, n_ovf);
    if (n_errors == 0) begin
      $display("tb_wildcard_glob_matcher_core: clean");
    end else begin
      $display("tb_wildcard_glob_matcher_core: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wgm_pkg.sv
sv/wgm_cell.sv
sv/wildcard_glob_matcher_core.sv
dv/tb_wildcard_glob_matcher_core.sv
